[sv/dlr_pkg.sv]
`default_nettype none

package dlr_pkg;

   // default coordinate width and the fixed width of the pixel ports
   localparam int DEF_COORD_WIDTH = 7;
   localparam int PIX_WIDTH       = 7;

   // controller to datapath commands
   typedef struct packed {
      logic load;     // latch line setup from the request
      logic step;     // advance the walk by one pixel
      logic capture;  // load the current pixel into the result register
   } dlr_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic emit;       // current pixel is an even-numbered one
      logic last_step;  // no major-axis steps left
      logic last_emit;  // current emitted pixel is the final emitted one
   } dlr_status_type;

endpackage

`default_nettype wire

[sv/dlr_ctrl.sv]
`default_nettype none

module dlr_ctrl
   import dlr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wire dlr_status_type stat,
   output dlr_cmd_type         cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      slot_free;
   logic      fire;

   assign slot_free = !out_valid_ff || rsp_ready;
   // an odd pixel needs no slot, an even one waits for a free result register
   assign fire      = (state_ff == ST_WALK) && (!stat.emit || slot_free);

   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.step     = 1'b0;
      cmd.capture  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (fire) begin
               cmd.capture = stat.emit;
               if (stat.last_step) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.capture) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;

endmodule

`default_nettype wire

[sv/dlr_datapath.sv]
`default_nettype none

module dlr_datapath
   import dlr_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
)
(
   input  wire logic                 clock,
   input  wire logic [PIX_WIDTH-1:0] req_start_x,
   input  wire logic [PIX_WIDTH-1:0] req_end_x,
   input  wire logic [PIX_WIDTH-1:0] req_start_y,
   input  wire logic [PIX_WIDTH-1:0] req_end_y,
   input  wire dlr_cmd_type          cmd,
   output dlr_status_type            stat,
   output logic [PIX_WIDTH-1:0]      rsp_pixel_x,
   output logic [PIX_WIDTH-1:0]      rsp_pixel_y,
   output logic                      rsp_last_pixel
);

   localparam int ERR_WIDTH = COORD_WIDTH + 3;

   logic [COORD_WIDTH-1:0]        x0, x1, y0, y1;
   logic                          xdown, ydown, ymajor;
   logic [COORD_WIDTH-1:0]        dx, dy, major_l, minor_l;
   logic signed [ERR_WIDTH-1:0]   err_init;

   logic [COORD_WIDTH-1:0]        cur_x_ff, cur_x_in;
   logic [COORD_WIDTH-1:0]        cur_y_ff, cur_y_in;
   logic signed [ERR_WIDTH-1:0]   err_ff, err_in;
   logic [COORD_WIDTH-1:0]        steps_ff, steps_in;
   logic                          parity_ff, parity_in;
   logic [COORD_WIDTH-1:0]        dx_ff, dy_ff;
   logic                          xdown_ff, ydown_ff, ymajor_ff;

   logic [COORD_WIDTH-1:0]        major_s, minor_s;
   logic signed [ERR_WIDTH-1:0]   inc_step, inc_stay;
   logic [COORD_WIDTH-1:0]        x_next, y_next;

   logic [PIX_WIDTH-1:0]          pix_x_ff, pix_y_ff;
   logic                          last_ff;

   // line setup from the masked request
   assign x0      = req_start_x[COORD_WIDTH-1:0];
   assign x1      = req_end_x[COORD_WIDTH-1:0];
   assign y0      = req_start_y[COORD_WIDTH-1:0];
   assign y1      = req_end_y[COORD_WIDTH-1:0];
   assign xdown   = (x1 < x0);
   assign ydown   = (y1 < y0);
   assign dx      = xdown ? (x0 - x1) : (x1 - x0);
   assign dy      = ydown ? (y0 - y1) : (y1 - y0);
   assign ymajor  = !(dx > dy);
   assign major_l = ymajor ? dy : dx;
   assign minor_l = ymajor ? dx : dy;
   assign err_init = (ERR_WIDTH'(minor_l) << 1) - ERR_WIDTH'(major_l);

   // per-step increments from the stored setup
   assign major_s  = ymajor_ff ? dy_ff : dx_ff;
   assign minor_s  = ymajor_ff ? dx_ff : dy_ff;
   assign inc_step = (ERR_WIDTH'(minor_s) - ERR_WIDTH'(major_s)) << 1;
   assign inc_stay = ERR_WIDTH'(minor_s) << 1;
   assign x_next   = xdown_ff ? (cur_x_ff - COORD_WIDTH'(1)) : (cur_x_ff + COORD_WIDTH'(1));
   assign y_next   = ydown_ff ? (cur_y_ff - COORD_WIDTH'(1)) : (cur_y_ff + COORD_WIDTH'(1));

   always_comb begin
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      err_in    = err_ff;
      steps_in  = steps_ff;
      parity_in = parity_ff;
      if (cmd.load) begin
         cur_x_in  = x0;
         cur_y_in  = y0;
         err_in    = err_init;
         steps_in  = major_l;
         parity_in = 1'b0;
      end else if (cmd.step) begin
         if (!err_ff[ERR_WIDTH-1]) begin
            err_in = err_ff + inc_step;
            if (ymajor_ff) begin
               cur_x_in = x_next;
            end else begin
               cur_y_in = y_next;
            end
         end else begin
            err_in = err_ff + inc_stay;
         end
         if (ymajor_ff) begin
            cur_y_in = y_next;
         end else begin
            cur_x_in = x_next;
         end
         steps_in  = steps_ff - COORD_WIDTH'(1);
         parity_in = !parity_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff  <= cur_x_in;
      cur_y_ff  <= cur_y_in;
      err_ff    <= err_in;
      steps_ff  <= steps_in;
      parity_ff <= parity_in;
      if (cmd.load) begin
         dx_ff     <= dx;
         dy_ff     <= dy;
         xdown_ff  <= xdown;
         ydown_ff  <= ydown;
         ymajor_ff <= ymajor;
      end
      if (cmd.capture) begin
         pix_x_ff <= PIX_WIDTH'(cur_x_ff);
         pix_y_ff <= PIX_WIDTH'(cur_y_ff);
         last_ff  <= stat.last_emit;
      end
   end

   assign stat.emit      = !parity_ff;
   assign stat.last_step = (steps_ff == '0);
   // an even pixel is the final emitted one when at most one step remains
   assign stat.last_emit = (steps_ff <= COORD_WIDTH'(1));

   assign rsp_pixel_x    = pix_x_ff;
   assign rsp_pixel_y    = pix_y_ff;
   assign rsp_last_pixel = last_ff;

endmodule

`default_nettype wire

[sv/dashed_line_rasterizer.sv]
// channel | handshake             | payload
// req     | req_valid, req_ready  | req_start_x, req_end_x, req_start_y, req_end_y
// rsp     | rsp_valid, rsp_ready  | rsp_pixel_x, rsp_pixel_y, rsp_last_pixel
//
// one transaction on req is one line; it yields one rsp transaction per even pixel
// a line is accepted from idle, then the single-step bresenham loop walks its major delta + 1
//    pixels in turn, up to 128 pixels at the default width
// reset is synchronous and active high; it clears the controller and the result valid
// rsp stalls only hold the walk on even pixels; odd pixels step through regardless
// req_ready is low while a line is walked; a finished pixel waits in the result register
`default_nettype none

module dashed_line_rasterizer
   import dlr_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // line request
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [PIX_WIDTH-1:0] req_start_x,
   input  wire logic [PIX_WIDTH-1:0] req_end_x,
   input  wire logic [PIX_WIDTH-1:0] req_start_y,
   input  wire logic [PIX_WIDTH-1:0] req_end_y,
   // pixel results
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [PIX_WIDTH-1:0]      rsp_pixel_x,
   output logic [PIX_WIDTH-1:0]      rsp_pixel_y,
   output logic                      rsp_last_pixel
);

   // command and status between controller and datapath
   dlr_cmd_type    cmd;
   dlr_status_type stat;

   // sequencer: idle / walk, owns the result valid
   dlr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // bresenham walk registers and the result register
   dlr_datapath #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .req_start_x    (req_start_x),
      .req_end_x      (req_end_x),
      .req_start_y    (req_start_y),
      .req_end_y      (req_end_y),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last_pixel (rsp_last_pixel)
   );

   // a line is only latched on an accepted request
   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_valid && req_ready))
      else $error("line setup loaded without a request transaction");

   // the walk never steps past the end point
   a_no_overstep: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !stat.last_step)
      else $error("walk stepped with no steps left");

   // capturing the end point ends the line and frees the request side
   a_last_frees_req: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && stat.last_step) |=> (req_ready && rsp_valid && rsp_last_pixel))
      else $error("final pixel captured but line did not finish");

   // a pixel is never captured over an unconsumed result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

[tb/sv/dlr_line_checker.sv]
`timescale 1ns / 100ps

module dlr_line_checker
   import dlr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic [PIX_WIDTH-1:0] req_start_x,
   input  wire logic [PIX_WIDTH-1:0] req_end_x,
   input  wire logic [PIX_WIDTH-1:0] req_start_y,
   input  wire logic [PIX_WIDTH-1:0] req_end_y,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic [PIX_WIDTH-1:0] rsp_pixel_x,
   input  wire logic [PIX_WIDTH-1:0] rsp_pixel_y,
   input  wire logic                 rsp_last_pixel,
   output int                        error_count,
   output int                        pixels_outstanding
);

   typedef struct packed {
      logic [PIX_WIDTH-1:0] x;
      logic [PIX_WIDTH-1:0] y;
      logic                 last;
   } dot_pixel_type;

   dot_pixel_type pending_pixels[$];
   int            mismatch_total = 0;

   function automatic logic [PIX_WIDTH-1:0] step_coord(input logic [PIX_WIDTH-1:0] v,
                                                       input logic down);
      return down ? v - 1'b1 : v + 1'b1;
   endfunction

   // bresenham walk, keeping the even-numbered pixels only
   task automatic walk_dotted_line(input logic [PIX_WIDTH-1:0] sx, ex, sy, ey);
      logic                 x_down, y_down, y_major;
      int                   dx, dy, major, minor, err, last_idx;
      logic [PIX_WIDTH-1:0] px, py;
      dot_pixel_type        dot;
      begin
         x_down   = ex < sx;
         y_down   = ey < sy;
         dx       = x_down ? sx - ex : ex - sx;
         dy       = y_down ? sy - ey : ey - sy;
         // ties go to y
         y_major  = !(dx > dy);
         major    = y_major ? dy : dx;
         minor    = y_major ? dx : dy;
         err      = 2 * minor - major;
         last_idx = major & ~1;
         px       = sx;
         py       = sy;
         for (int i = 0; i <= major; i++) begin
            if (i % 2 == 0) begin
               dot.x    = px;
               dot.y    = py;
               dot.last = (i == last_idx);
               pending_pixels.push_back(dot);
            end
            if (i < major) begin
               if (err >= 0) begin
                  if (y_major) px = step_coord(px, x_down);
                  else         py = step_coord(py, y_down);
                  err += 2 * (minor - major);
               end else begin
                  err += 2 * minor;
               end
               if (y_major) py = step_coord(py, y_down);
               else         px = step_coord(px, x_down);
            end
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      dot_pixel_type got, want;
      if (reset) begin
         pending_pixels.delete();
      end else begin
         if (req_valid && req_ready)
            walk_dotted_line(req_start_x, req_end_x, req_start_y, req_end_y);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_pixel_x, rsp_pixel_y, rsp_last_pixel};
            if (pending_pixels.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("%0t: unexpected pixel x=%0d y=%0d last=%0d", $realtime,
                           got.x, got.y, got.last);
            end else begin
               want = pending_pixels.pop_front();
               if (got.x !== want.x || got.y !== want.y || got.last !== want.last) begin
                  mismatch_total++;
                  if (mismatch_total <= 10)
                     $display("%0t: mismatch exp x=%0d y=%0d last=%0d got x=%0d y=%0d last=%0d",
                              $realtime, want.x, want.y, want.last, got.x, got.y, got.last);
               end
            end
         end
      end
      error_count        <= mismatch_total;
      pixels_outstanding <= pending_pixels.size();
   end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import dlr_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [PIX_WIDTH-1:0] req_start_x;
   logic [PIX_WIDTH-1:0] req_end_x;
   logic [PIX_WIDTH-1:0] req_start_y;
   logic [PIX_WIDTH-1:0] req_end_y;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [PIX_WIDTH-1:0] rsp_pixel_x;
   logic [PIX_WIDTH-1:0] rsp_pixel_y;
   logic                 rsp_last_pixel;
   int                   error_count;
   int                   pixels_outstanding;

   localparam int COORD_MAX = (1 << PIX_WIDTH) - 1;

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   dashed_line_rasterizer u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_start_x    (req_start_x),
      .req_end_x      (req_end_x),
      .req_start_y    (req_start_y),
      .req_end_y      (req_end_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last_pixel (rsp_last_pixel)
   );

   // watches both channels, predicts the dotted pixels and compares them
   dlr_line_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_start_x        (req_start_x),
      .req_end_x          (req_end_x),
      .req_start_y        (req_start_y),
      .req_end_y          (req_end_y),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixel_x        (rsp_pixel_x),
      .rsp_pixel_y        (rsp_pixel_y),
      .rsp_last_pixel     (rsp_last_pixel),
      .error_count        (error_count),
      .pixels_outstanding (pixels_outstanding)
   );

   // clamp a coordinate into the legal range
   function automatic int clamp_coord(input int c);
      return (c < 0) ? 0 : (c > COORD_MAX) ? COORD_MAX : c;
   endfunction

   // a point within 7 pixels of c, for short lines
   function automatic int near_coord(input int c);
      return clamp_coord(c + $urandom_range(0, 14) - 7);
   endfunction

   // offer one line request and hold it until the transaction completes
   task automatic send_line(input int sx, ex, sy, ey, input bit gaps_on);
      begin
         // random sender gaps: before each request, one more idle cycle with a chance of 31 in a hundred
         while (gaps_on && $urandom_range(0, 99) < 31) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid   <= 1'b1;
         req_start_x <= PIX_WIDTH'(sx);
         req_end_x   <= PIX_WIDTH'(ex);
         req_start_y <= PIX_WIDTH'(sy);
         req_end_y   <= PIX_WIDTH'(ey);
         do @(posedge clock); while (!req_ready);
      end
   endtask

   // receiver: random stalls, one calm stretch and one long hold-off
   initial begin : pixel_sink
      int cycle_count;
      rsp_ready   <= 1'b0;
      cycle_count = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= 1500 && cycle_count < 1900)
            // long hold-off so the result register fills and the walk stalls with req_ready low
            rsp_ready <= 1'b0;
         else if (cycle_count >= 6000 && cycle_count < 9000)
            rsp_ready <= 1'b1;
         else
            rsp_ready <= ($urandom_range(0, 99) >= 31);
      end
   end

   // stimulus and verdict
   initial begin : line_source
      int sx, ex, sy, ey, d, pick;
      bit gaps_on;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_start_x <= '0;
      req_end_x   <= '0;
      req_start_y <= '0;
      req_end_y   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed lines: sx, ex, sy, ey
      send_line(0, 0, 0, 0, 1);            // degenerate at the origin
      send_line(127, 127, 127, 127, 1);    // degenerate at the far corner
      send_line(0, 127, 0, 127, 1);        // full diagonal, equal deltas
      send_line(127, 0, 127, 0, 1);        // full diagonal reversed
      send_line(0, 127, 127, 0, 1);        // anti-diagonal
      send_line(0, 127, 40, 40, 1);        // horizontal, odd major delta
      send_line(0, 126, 40, 40, 1);        // horizontal, even major delta
      send_line(127, 0, 3, 3, 1);          // horizontal leftward
      send_line(60, 60, 0, 127, 1);        // vertical upward
      send_line(60, 60, 127, 1, 1);        // vertical downward, even
      send_line(10, 11, 20, 20, 1);        // single x step
      send_line(10, 10, 20, 21, 1);        // single y step
      send_line(10, 11, 20, 21, 1);        // single diagonal step
      send_line(5, 100, 10, 40, 1);        // shallow, x major
      send_line(100, 5, 40, 10, 1);        // shallow reversed
      send_line(10, 40, 5, 100, 1);        // steep, y major
      send_line(40, 10, 100, 5, 1);        // steep reversed
      send_line(0, 127, 126, 0, 1);        // x major by one
      send_line(3, 7, 9, 2, 1);
      send_line(85, 42, 21, 106, 1);       // alternating bit patterns

      // random lines, with one stretch of back-to-back transactions
      for (int n = 0; n < 450; n++) begin
         gaps_on = !(n >= 200 && n < 280);
         pick    = $urandom_range(0, 9);
         sx      = $urandom_range(0, COORD_MAX);
         sy      = $urandom_range(0, COORD_MAX);
         ex      = $urandom_range(0, COORD_MAX);
         ey      = $urandom_range(0, COORD_MAX);
         case (pick)
            4, 5, 6: begin
               // short line
               ex = near_coord(sx);
               ey = near_coord(sy);
            end
            7: begin
               // equal deltas in any direction
               d  = (ex > sx) ? ex - sx : sx - ex;
               sy = $urandom_range(0, COORD_MAX - d);
               ey = sy + d;
               if ($urandom_range(0, 1)) begin
                  d  = sy;
                  sy = ey;
                  ey = d;
               end
            end
            8: begin
               // axis aligned
               if ($urandom_range(0, 1)) ey = sy;
               else                      ex = sx;
            end
            9: begin
               // corners or a single point
               if ($urandom_range(0, 1)) begin
                  sx = $urandom_range(0, 1) * COORD_MAX;
                  ex = $urandom_range(0, 1) * COORD_MAX;
                  sy = $urandom_range(0, 1) * COORD_MAX;
                  ey = $urandom_range(0, 1) * COORD_MAX;
               end else begin
                  ex = sx;
                  ey = sy;
               end
            end
            default: ;
         endcase
         send_line(sx, ex, sy, ey, gaps_on);
      end
      req_valid <= 1'b0;

      // drain, then allow a full line walk of settling time
      do @(posedge clock); while (pixels_outstanding != 0);
      repeat (150) @(posedge clock);

      if (error_count == 0 && pixels_outstanding == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #12_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

[filelist.f]
sv/dlr_pkg.sv
sv/dlr_ctrl.sv
sv/dlr_datapath.sv
sv/dashed_line_rasterizer.sv
tb/sv/dlr_line_checker.sv
tb/sv/tb_top.sv
